@@ hdl/ogft_pkg.sv @@
// Shared types and constants for the occupancy grid frontier test.
// Sequencer states, register indexes, neighbour offset tables and divider interface.
// No dependencies.
`default_nettype none

package ogft_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FREE_LIMIT  = 2'd2;

   // Item kinds carried on req_tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [7:0] CELL_UNKNOWN = 8'hFF;

   // 8-neighbour offsets, same order as the scan
   localparam logic signed [1:0] DROW [8] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1,
                                              -2'sd1, -2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] DCOL [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                              -2'sd1, 2'sd1, 2'sd1, -2'sd1};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREAD,
      ST_PCHK,
      ST_NADDR,
      ST_NMUL,
      ST_NREAD,
      ST_NCHK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [8:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
      logic [8:0]  remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ hdl/ogft_div.sv @@
// Restoring divider that splits a cell index into row and column.
// One quotient bit per cycle; uses ogft_pkg.
`default_nettype none

module ogft_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ogft_pkg::div_req_type div_req,
   output      ogft_pkg::div_rsp_type div_rsp
);
   import ogft_pkg::*;

   logic [15:0] quot_ff, quot_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  dvsr_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [9:0]  trial;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, quot_ff[15]};
      ge      = trial >= {1'b0, dvsr_ff};
      rem_in  = ge ? 9'(trial - {1'b0, dvsr_ff}) : trial[8:0];
      quot_in = {quot_ff[14:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quot_ff <= div_req.dividend;
         rem_ff  <= '0;
         dvsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

@@ hdl/occupancy_grid_frontier_test.sv @@
// A write is stored at once and the block stays ready for the next transaction.
// A query: accept, divide, then a read and check of the cell when the index is inside
// the grid, then address, multiply and read per neighbour probed (and a check unless it
// lies off the grid or past the memory), both levels; then result and any rsp_tready wait.
// Throughput: one query at a time, set by the single grid memory port and the sequencer.
// Reset clears the sequencer and the output valid flag and sets width, height and free limit to 100;
// grid memory contents are not cleared and must be written before they are queried.
`default_nettype none

module occupancy_grid_frontier_test #(
   parameter int MAX_CELLS = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,  // [15:0] cell_index, [23:16] cell_value
   input  wire logic        req_tuser,  // [0] kind
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,  // [0] is_frontier, [1] out_of_range, [7:2] zero
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);
   import ogft_pkg::*;

   localparam int ADDR_W = $clog2(MAX_CELLS);
   localparam int IDX_W  = (ADDR_W + 1 > 19) ? ADDR_W + 1 : 19;

   logic [7:0] grid_mem [MAX_CELLS];
   logic [7:0] rd_data_ff;

   logic [8:0]  cfg_width_ff, cfg_height_ff;
   logic [6:0]  cfg_limit_ff;
   logic [17:0] area_ff;

   state_type state_ff, state_in;

   logic [15:0] pidx_ff;
   logic [8:0]  prow_ff, pcol_ff, nrow_ff, ncol_ff;
   logic [8:0]  cand_row_ff, cand_col_ff;
   logic        cand_ok_ff;
   logic [IDX_W-1:0] cand_idx_ff;
   logic [2:0]  k_ff, m_ff;
   logic        level_ff;
   logic [1:0]  cnt_ff;
   logic        res_frontier_ff, res_oor_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_data_ff;

   logic             req_fire, query_fire, write_fire;
   logic [IDX_W-1:0] wr_idx;
   logic             oor;
   logic             cell_free, cell_unknown;
   logic             cand_hit, step_last, found;
   logic             rsp_free, rsp_load;
   logic             mem_re;
   logic [ADDR_W-1:0] mem_ra;
   logic [8:0]       ctr_row, ctr_col;
   logic [2:0]       off;
   logic signed [10:0] cr, cc;
   logic             in_grid;

   div_req_type div_req;
   div_rsp_type div_rsp;

   ogft_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire   = req_tvalid && req_tready;
   assign query_fire = req_fire && (req_tuser == KIND_QUERY);
   assign wr_idx     = IDX_W'(req_tdata[15:0]);
   assign write_fire = req_fire && (req_tuser == KIND_WRITE) && (wr_idx < IDX_W'(MAX_CELLS));

   assign div_req.start    = query_fire;
   assign div_req.dividend = req_tdata[15:0];
   assign div_req.divisor  = cfg_width_ff;

   assign oor = (18'(pidx_ff) >= area_ff) || (IDX_W'(pidx_ff) >= IDX_W'(MAX_CELLS));

   assign cell_free    = !rd_data_ff[7] && (rd_data_ff[6:0] <= cfg_limit_ff);
   assign cell_unknown = rd_data_ff == CELL_UNKNOWN;
   assign cand_hit     = cand_ok_ff && (cand_idx_ff < IDX_W'(MAX_CELLS));
   assign step_last    = (k_ff == 3'd7) && (!level_ff || m_ff == 3'd7);
   assign found        = level_ff && cell_unknown && (cnt_ff == 2'd2);
   assign rsp_free     = !rsp_valid_ff || rsp_tready;

   // Neighbour coordinates around the current center
   always_comb begin
      ctr_row = level_ff ? nrow_ff : prow_ff;
      ctr_col = level_ff ? ncol_ff : pcol_ff;
      off     = level_ff ? m_ff : k_ff;
      cr      = signed'({2'b00, ctr_row}) + 11'(DROW[off]);
      cc      = signed'({2'b00, ctr_col}) + 11'(DCOL[off]);
      in_grid = !cr[10] && !cc[10] &&
                (cr < signed'({2'b00, cfg_height_ff})) &&
                (cc < signed'({2'b00, cfg_width_ff}));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (query_fire) state_in = ST_DIV;
         ST_DIV:    if (div_rsp.done) state_in = oor ? ST_RESULT : ST_PREAD;
         ST_PREAD:  state_in = ST_PCHK;
         ST_PCHK:   state_in = cell_free ? ST_NADDR : ST_RESULT;
         ST_NADDR:  state_in = ST_NMUL;
         ST_NMUL:   state_in = ST_NREAD;
         ST_NREAD: begin
            if (cand_hit) state_in = ST_NCHK;
            else          state_in = step_last ? ST_RESULT : ST_NADDR;
         end
         ST_NCHK: begin
            if (!level_ff && cell_unknown) state_in = ST_NADDR;
            else if (found)                state_in = ST_RESULT;
            else                           state_in = step_last ? ST_RESULT : ST_NADDR;
         end
         ST_RESULT: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      mem_ra     = cand_idx_ff[ADDR_W-1:0];
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_PREAD: begin
            mem_re = 1'b1;
            mem_ra = ADDR_W'(IDX_W'(pidx_ff));
         end
         ST_NREAD:  mem_re = cand_hit;
         ST_RESULT: rsp_load = rsp_free;
         default:   mem_re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (write_fire) grid_mem[wr_idx[ADDR_W-1:0]] <= req_tdata[23:16];
      if (mem_re) rd_data_ff <= grid_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 9'd100;
         cfg_height_ff <= 9'd100;
         cfg_limit_ff  <= 7'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  cfg_width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: cfg_height_ff <= csr_wdata;
            CSR_FREE_LIMIT:  cfg_limit_ff  <= csr_wdata[6:0];
            default:         cfg_limit_ff  <= cfg_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= 18'(cfg_width_ff) * 18'(cfg_height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath of the scan
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= {res_oor_ff, res_frontier_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               pidx_ff         <= req_tdata[15:0];
               res_frontier_ff <= 1'b0;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_oor_ff <= oor;
               prow_ff    <= div_rsp.quotient[8:0];
               pcol_ff    <= div_rsp.remainder;
               k_ff       <= '0;
               m_ff       <= '0;
               level_ff   <= 1'b0;
            end
         end
         ST_NADDR: begin
            cand_row_ff <= cr[8:0];
            cand_col_ff <= cc[8:0];
            cand_ok_ff  <= in_grid;
         end
         ST_NMUL: begin
            cand_idx_ff <= IDX_W'(cand_row_ff) * IDX_W'(cfg_width_ff) + IDX_W'(cand_col_ff);
         end
         ST_NREAD, ST_NCHK: begin
            if (state_ff == ST_NCHK && !level_ff && cell_unknown) begin
               // descend into the unknown neighbour
               nrow_ff  <= cand_row_ff;
               ncol_ff  <= cand_col_ff;
               level_ff <= 1'b1;
               m_ff     <= '0;
               cnt_ff   <= '0;
            end else if (state_ff == ST_NCHK && found) begin
               res_frontier_ff <= 1'b1;
            end else if (state_ff == ST_NCHK || !cand_hit) begin
               if (state_ff == ST_NCHK && level_ff && cell_unknown) cnt_ff <= cnt_ff + 2'd1;
               if (level_ff && m_ff != 3'd7) begin
                  m_ff <= m_ff + 3'd1;
               end else begin
                  level_ff <= 1'b0;
                  k_ff     <= k_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

endmodule

`default_nettype wire

@@ hdl/ogft_check.sv @@
// Port-level checks for occupancy_grid_frontier_test, attached by bind.
// Depends on the top level's port list and on ogft_pkg.
`default_nettype none

module ogft_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);
   import ogft_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("frontier flagged for out-of-range query");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b0)
      else $error("result padding not zero");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_QUERY |=> !req_tready)
      else $error("query did not occupy the block");

   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_WRITE |=> req_tready)
      else $error("write transaction stalled the input");

endmodule

bind occupancy_grid_frontier_test ogft_check u_ogft_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
